[src/dsa_pkg.sv]
package dsa_pkg;

    // Depth of the free stack and the largest number of slots.
    localparam int CAPACITY = 1024;
    localparam int STACK_AW = $clog2(CAPACITY);

    // Fixed field widths.
    localparam int IDX_W   = 10;
    localparam int CNT_W   = 11;
    localparam int ADDR_W  = 48;
    localparam int LIMIT_W = 11;
    localparam int STRIDE_W = 9;

    // APB data and address widths; registers sit at byte address 8*i.
    localparam int APB_DW = 64;
    localparam int APB_AW = 5;

    // Largest slot count, at counter width.
    localparam logic [CNT_W-1:0] CAPACITY_CNT = CNT_W'(CAPACITY);

    // Register reset values.
    localparam logic [LIMIT_W-1:0]  SLOT_LIMIT_RST  = LIMIT_W'(1024);
    localparam logic [STRIDE_W-1:0] SLOT_STRIDE_RST = STRIDE_W'(32);
    localparam logic [ADDR_W-1:0]   HEAP_BASE_RST   = '0;

    typedef enum logic [1:0] {
        REG_SLOT_LIMIT  = 2'd0,
        REG_SLOT_STRIDE = 2'd1,
        REG_HEAP_BASE   = 2'd2
    } reg_index_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EXHAUSTED = 2'd1,
        STATUS_NO_ACTIVE = 2'd2
    } status_t;

    // Request word.
    typedef struct packed {
        opcode_t           opcode;
        logic [IDX_W-1:0]  release_index;
    } in_word_t;

    // Result word.
    typedef struct packed {
        status_t           status;
        logic [IDX_W-1:0]  slot_index;
        logic [ADDR_W-1:0] slot_address;
        logic [CNT_W-1:0]  live_count;
    } out_word_t;

    // Free stack access issued by the control stage.
    typedef struct packed {
        logic                wr_en;
        logic [STACK_AW-1:0] wr_addr;
        logic [IDX_W-1:0]    wr_data;
        logic                rd_en;
        logic [STACK_AW-1:0] rd_addr;
    } stack_req_t;

    // Decision handed from the control stage to the address stage.
    typedef struct packed {
        status_t           status;
        logic              use_slot;
        logic              pop;
        logic [IDX_W-1:0]  fresh_idx;
        logic [CNT_W-1:0]  live_count;
    } slot_cmd_t;

    // Configuration values seen by the datapath.
    typedef struct packed {
        logic [LIMIT_W-1:0]  slot_limit;
        logic [STRIDE_W-1:0] slot_stride;
        logic [ADDR_W-1:0]   heap_base;
    } cfg_t;

endpackage

[src/dsa_regs.sv]
module dsa_regs
    import dsa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [LIMIT_W-1:0]  slot_limit_reg;
    logic [STRIDE_W-1:0] slot_stride_reg;
    logic [ADDR_W-1:0]   heap_base_reg;
    logic                wr_en;
    reg_index_t          reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = reg_index_t'(paddr[APB_AW-1:3]);

    // Register writes in the access phase.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_limit_reg  <= SLOT_LIMIT_RST;
            slot_stride_reg <= SLOT_STRIDE_RST;
            heap_base_reg   <= HEAP_BASE_RST;
        end else if (wr_en) begin
            case (reg_sel)
                REG_SLOT_LIMIT:  slot_limit_reg  <= pwdata[LIMIT_W-1:0];
                REG_SLOT_STRIDE: slot_stride_reg <= pwdata[STRIDE_W-1:0];
                REG_HEAP_BASE:   heap_base_reg   <= pwdata[ADDR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read back.
    always_comb begin
        case (reg_sel)
            REG_SLOT_LIMIT:  prdata = APB_DW'(slot_limit_reg);
            REG_SLOT_STRIDE: prdata = APB_DW'(slot_stride_reg);
            REG_HEAP_BASE:   prdata = APB_DW'(heap_base_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.slot_limit  = slot_limit_reg;
    assign cfg.slot_stride = slot_stride_reg;
    assign cfg.heap_base   = heap_base_reg;

endmodule

[src/dsa_free_stack.sv]
module dsa_free_stack
    import dsa_pkg::*;
(
    input  logic             aclk,
    input  stack_req_t       req,
    output logic [IDX_W-1:0] rd_data
);

    logic [IDX_W-1:0] mem [CAPACITY];
    logic [IDX_W-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/dsa_ctrl.sv]
module dsa_ctrl
    import dsa_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_word_t         s_word,
    input  logic [LIMIT_W-1:0] slot_limit,
    output stack_req_t       stack_req,
    output logic             cmd_valid,
    input  logic             cmd_ready,
    output slot_cmd_t        cmd
);

    logic [CNT_W-1:0] fresh_index_reg, fresh_index_next;
    logic [CNT_W-1:0] stack_depth_reg, stack_depth_next;
    logic [CNT_W-1:0] active_slots_reg, active_slots_next;
    logic             cmd_valid_reg;
    slot_cmd_t        cmd_reg, cmd_next;
    logic             accept;
    logic [CNT_W-1:0] limit;

    assign s_ready = !cmd_valid_reg || cmd_ready;
    assign accept  = s_valid && s_ready;
    assign limit   = (slot_limit < CAPACITY_CNT) ? slot_limit : CAPACITY_CNT;

    // Decide the request against the current counts.
    always_comb begin
        fresh_index_next  = fresh_index_reg;
        stack_depth_next  = stack_depth_reg;
        active_slots_next = active_slots_reg;
        stack_req         = '0;
        stack_req.wr_data = s_word.release_index;
        cmd_next          = '0;
        cmd_next.status   = STATUS_OK;

        case (s_word.opcode)
            OP_ALLOC: begin
                if (fresh_index_reg < limit) begin
                    // Hand out the next never-used slot.
                    cmd_next.use_slot  = 1'b1;
                    cmd_next.fresh_idx = fresh_index_reg[IDX_W-1:0];
                    fresh_index_next   = fresh_index_reg + CNT_W'(1);
                    active_slots_next  = active_slots_reg + CNT_W'(1);
                end else if (stack_depth_reg != '0) begin
                    // Pop the most recently freed slot.
                    cmd_next.use_slot = 1'b1;
                    cmd_next.pop      = 1'b1;
                    stack_depth_next  = stack_depth_reg - CNT_W'(1);
                    stack_req.rd_en   = accept;
                    stack_req.rd_addr = stack_depth_next[STACK_AW-1:0];
                    active_slots_next = active_slots_reg + CNT_W'(1);
                end else begin
                    cmd_next.status = STATUS_EXHAUSTED;
                end
            end
            OP_FREE: begin
                if (active_slots_reg == '0) begin
                    cmd_next.status = STATUS_NO_ACTIVE;
                end else begin
                    if (stack_depth_reg < CAPACITY_CNT) begin
                        stack_req.wr_en   = accept;
                        stack_req.wr_addr = stack_depth_reg[STACK_AW-1:0];
                        stack_depth_next  = stack_depth_reg + CNT_W'(1);
                    end
                    active_slots_next = active_slots_reg - CNT_W'(1);
                end
            end
            default: begin
            end
        endcase

        cmd_next.live_count = active_slots_next;
    end

    // Counts and the hand-off register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fresh_index_reg  <= '0;
            stack_depth_reg  <= '0;
            active_slots_reg <= '0;
            cmd_valid_reg    <= 1'b0;
        end else begin
            if (accept) begin
                fresh_index_reg  <= fresh_index_next;
                stack_depth_reg  <= stack_depth_next;
                active_slots_reg <= active_slots_next;
            end
            if (s_ready) begin
                cmd_valid_reg <= s_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

endmodule

[src/dsa_addr.sv]
module dsa_addr
    import dsa_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  slot_cmd_t        cmd,
    input  logic [IDX_W-1:0] pop_data,
    input  cfg_t             cfg,
    output logic             m_valid,
    input  logic             m_ready,
    output out_word_t        m_word
);

    logic                         m_valid_reg;
    out_word_t                    m_word_reg, m_word_next;
    logic [IDX_W-1:0]             idx;
    logic [IDX_W+STRIDE_W-1:0]    offset;

    assign cmd_ready = !m_valid_reg || m_ready;

    // Pick the slot and form base + index * stride, wrapped to 48 bits.
    always_comb begin
        idx    = cmd.pop ? pop_data : cmd.fresh_idx;
        offset = (IDX_W+STRIDE_W)'(idx) * (IDX_W+STRIDE_W)'(cfg.slot_stride);
        m_word_next.status     = cmd.status;
        m_word_next.live_count = cmd.live_count;
        if (cmd.use_slot) begin
            m_word_next.slot_index   = idx;
            m_word_next.slot_address = cfg.heap_base + ADDR_W'(offset);
        end else begin
            m_word_next.slot_index   = '0;
            m_word_next.slot_address = '0;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd_ready) begin
            m_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_ready && cmd_valid) begin
            m_word_reg <= m_word_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

endmodule

[src/descriptor_slot_allocator.sv]
// Slot allocator for a heap of fixed-size slots. An allocate word takes the
// next never-used slot while that index is below min(slot_limit, 1024), and
// otherwise pops the most recently freed slot; it returns the index and
// heap_base + index * slot_stride modulo 2^48. A free word pushes its index
// and lowers the live count. Exhaustion and a free with no live slots report
// an error status and leave the state as it was. The block takes one word
// per cycle while the result side is ready. The decision and the free stack's
// registered read are captured at the edge that accepts a request, and the
// multiply-add of base, index and stride lands in the result register when
// the result side can take it. The user must write registers through the APB
// port only while no request is in flight; the block itself does not enforce this.
module descriptor_slot_allocator
    import dsa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_word_t          s_word,
    output logic              m_valid,
    input  logic              m_ready,
    output out_word_t         m_word
);

    cfg_t             cfg;
    stack_req_t       stack_req;
    logic [IDX_W-1:0] pop_data;
    logic             cmd_valid;
    logic             cmd_ready;
    slot_cmd_t        cmd;

    dsa_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dsa_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_word     (s_word),
        .slot_limit (cfg.slot_limit),
        .stack_req  (stack_req),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd)
    );

    dsa_free_stack u_free_stack (
        .aclk    (aclk),
        .req     (stack_req),
        .rd_data (pop_data)
    );

    dsa_addr u_addr (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .pop_data  (pop_data),
        .cfg       (cfg),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word)
    );

endmodule

[src/dsa_checker.sv]
module dsa_checker
    import dsa_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_word
);

    // A stalled result word holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word))
        else $error("result word changed while stalled");

    // Error results carry no slot.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.status != STATUS_OK |->
            m_word.slot_index == '0 && m_word.slot_address == '0)
        else $error("error result carries a slot");

    // A free with nothing live reports zero live slots.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.status == STATUS_NO_ACTIVE |-> m_word.live_count == '0)
        else $error("no-active status with live slots");

    // The live count never exceeds the heap size.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_word.live_count <= CAPACITY_CNT)
        else $error("live count above capacity");

endmodule

bind descriptor_slot_allocator dsa_checker u_dsa_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_word  (m_word)
);
